>>> design/afp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afp_pkg: shared types, codes and arithmetic for the transform prefix block
// Holds the item codes, table entry layouts and the compose/apply functions.
// ----------------------------------------------------------------------------
package afp_pkg;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] KIND_CW  = 2'd0;
	localparam logic [1:0] KIND_CCW = 2'd1;
	localparam logic [1:0] KIND_RX  = 2'd2;
	localparam logic [1:0] KIND_RY  = 2'd3;

	// unit codes of the linear part: zero, plus one, minus one
	localparam logic [1:0] U_ZERO = 2'b00;
	localparam logic [1:0] U_POS  = 2'b01;
	localparam logic [1:0] U_NEG  = 2'b11;

	localparam int COORD_W = 32;
	localparam int WIDE_W  = 36;

	// element i of the 2x2 matrix sits at bits 2i+1:2i
	localparam logic [7:0] LIN_IDENTITY = {U_POS, U_ZERO, U_ZERO, U_POS};

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} afp_state_t;

	typedef struct packed {
		logic                      written;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} pt_entry_t;

	typedef struct packed {
		logic [7:0]        linear;
		logic [WIDE_W-1:0] shift_x;
		logic [WIDE_W-1:0] shift_y;
	} pf_entry_t;

	typedef struct packed {
		logic [WIDE_W-1:0] x;
		logic [WIDE_W-1:0] y;
	} xy_t;

	function automatic logic [1:0] neg_unit(input logic [1:0] c);
		logic [1:0] r;
		case (c)
			U_POS:   r = U_NEG;
			U_NEG:   r = U_POS;
			default: r = U_ZERO;
		endcase
		return r;
	endfunction

	function automatic logic [WIDE_W-1:0] unit_mul(input logic [1:0] c,
		input logic [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] r;
		case (c)
			U_POS:   r = v;
			U_NEG:   r = ~v + WIDE_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// new prefix = transform of given kind applied after prev
	function automatic pf_entry_t compose(input pf_entry_t prev, input logic [1:0] kind,
		input logic [WIDE_W-1:0] twop);
		pf_entry_t         n;
		logic [1:0]        l0, l1, l2, l3;
		logic [WIDE_W-1:0] sx, sy, nsx, nsy;
		l0 = prev.linear[1:0];
		l1 = prev.linear[3:2];
		l2 = prev.linear[5:4];
		l3 = prev.linear[7:6];
		sx = prev.shift_x;
		sy = prev.shift_y;
		nsx = '0;
		nsy = '0;
		n.linear = '0;
		case (kind)
			KIND_CW: begin
				n.linear = {neg_unit(l1), neg_unit(l0), l3, l2};
				nsx = sy;
				nsy = ~sx + WIDE_W'(1);
			end
			KIND_CCW: begin
				n.linear = {l1, l0, neg_unit(l3), neg_unit(l2)};
				nsx = ~sy + WIDE_W'(1);
				nsy = sx;
			end
			KIND_RX: begin
				n.linear = {l3, l2, neg_unit(l1), neg_unit(l0)};
				nsx = twop - sx;
				nsy = sy;
			end
			default: begin
				n.linear = {neg_unit(l3), neg_unit(l2), l1, l0};
				nsx = sx;
				nsy = twop - sy;
			end
		endcase
		n.shift_x = nsx;
		n.shift_y = nsy;
		return n;
	endfunction

	function automatic xy_t apply(input pf_entry_t pf, input pt_entry_t pt);
		xy_t               r;
		logic [WIDE_W-1:0] px, py;
		px = {{(WIDE_W-COORD_W){pt.x[COORD_W-1]}}, pt.x};
		py = {{(WIDE_W-COORD_W){pt.y[COORD_W-1]}}, pt.y};
		r.x = unit_mul(pf.linear[1:0], px) + unit_mul(pf.linear[3:2], py) + pf.shift_x;
		r.y = unit_mul(pf.linear[5:4], px) + unit_mul(pf.linear[7:6], py) + pf.shift_y;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/afp_point_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afp_point_store: point table memory with written flags
// Single-port synchronous memory; a sweep after reset clears the flags.
// ----------------------------------------------------------------------------
module afp_point_store #(
	parameter int POINT_SLOTS = 1024,
	localparam int PA_W = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      we,
	input  wire                      re,
	input  wire [PA_W-1:0]           addr,
	input  wire afp_pkg::pt_entry_t  wdata,
	output afp_pkg::pt_entry_t       rdata,
	output logic                     clearing
);

	afp_pkg::pt_entry_t mem [POINT_SLOTS];
	afp_pkg::pt_entry_t rdata_q;
	logic [PA_W-1:0]    clr_q;
	logic               clearing_q;

	// clear sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			if (clr_q == PA_W'(POINT_SLOTS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + PA_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= '0;
		end else if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata    = rdata_q;
	assign clearing = clearing_q;

endmodule
`default_nettype wire

>>> design/afp_prefix_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afp_prefix_store: prefix transform memory
// One write port and one registered read port, entry i holds step i+1.
// ----------------------------------------------------------------------------
module afp_prefix_store #(
	parameter int STEP_SLOTS = 1024,
	localparam int SA_W = (STEP_SLOTS > 1) ? $clog2(STEP_SLOTS) : 1
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [SA_W-1:0]           waddr,
	input  wire afp_pkg::pf_entry_t  wdata,
	input  wire                      re,
	input  wire [SA_W-1:0]           raddr,
	output afp_pkg::pf_entry_t       rdata
);

	afp_pkg::pf_entry_t mem [STEP_SLOTS];
	afp_pkg::pf_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> design/affine_transform_prefix_apply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// affine_transform_prefix_apply: prefix composition of planar transforms
// Stores points and prefix transforms in memories; appends compose a new
// prefix step, queries apply a prefix step to a stored point.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   ------------------------------------------
//  item in   start && !busy          opcode, point_index, point_x, point_y,
//                                    transform_kind, mirror_line, step_index
//  result    done (one cycle)        result_x, result_y, query_error
//
//  a load is written at its accept edge
//  an append or a query reads memory at its accept edge, the data comes back in
//  the execute state, then the prefix is written or the result and done are
//  registered; the next item may be accepted in the cycle after execute
//  after reset the point flags are cleared while busy is held high
//  results cannot be stalled: done lasts exactly one cycle
//
module affine_transform_prefix_apply #(
	parameter int POINT_SLOTS = 1024,
	parameter int STEP_SLOTS  = 1024
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire  [1:0]        opcode,
	input  wire  [9:0]        point_index,
	input  wire  signed [31:0] point_x,
	input  wire  signed [31:0] point_y,
	input  wire  [1:0]        transform_kind,
	input  wire  signed [31:0] mirror_line,
	input  wire  [10:0]       step_index,
	output logic              done,
	output logic signed [35:0] result_x,
	output logic signed [35:0] result_y,
	output logic              query_error
);

	localparam int PA_W = (POINT_SLOTS > 1) ? $clog2(POINT_SLOTS) : 1;
	localparam int SA_W = (STEP_SLOTS > 1) ? $clog2(STEP_SLOTS) : 1;
	localparam int SC_W = $clog2(STEP_SLOTS + 1);
	localparam int W    = afp_pkg::WIDE_W;

	afp_pkg::afp_state_t state_q, state_d;

	// step counter and captured item fields
	logic [SC_W-1:0]  step_count_q;
	logic [1:0]       op_q;
	logic [1:0]       kind_q;
	logic [W-1:0]     twop_q;
	logic             ident_q;   // prefix is the identity, table read data unused
	logic             err_q;     // step beyond count or point slot out of range

	// result registers
	logic             done_q;
	logic [W-1:0]     res_x_q;
	logic [W-1:0]     res_y_q;
	logic             res_err_q;

	// memory interfaces
	logic               clearing;
	logic               pt_we, pt_re;
	logic [PA_W-1:0]    pt_addr;
	afp_pkg::pt_entry_t pt_wdata, pt_rdata;
	logic               pf_we, pf_re;
	logic [SA_W-1:0]    pf_waddr, pf_raddr;
	afp_pkg::pf_entry_t pf_wdata, pf_rdata;

	// combinational control
	logic               accept;
	logic               capture;
	logic               ident_d;
	logic               err_d;
	logic               pt_in_range;
	logic               step_room;
	logic [16:0]        pidx_ext;
	logic [16:0]        sidx_ext;
	logic [16:0]        count_ext;
	logic [16:0]        count_m1_ext;
	logic [16:0]        sidx_m1_ext;
	afp_pkg::pf_entry_t prev_pf;
	afp_pkg::xy_t       applied;

	assign pidx_ext     = {7'd0, point_index};
	assign sidx_ext     = {6'd0, step_index};
	assign count_ext    = 17'(step_count_q);
	assign count_m1_ext = 17'(step_count_q - SC_W'(1));
	assign sidx_m1_ext  = {6'd0, step_index - 11'd1};
	assign pt_in_range  = {22'd0, point_index} < 32'(POINT_SLOTS);
	assign step_room    = 32'(step_count_q) < 32'(STEP_SLOTS);
	assign accept       = start && !busy;
	assign pt_addr      = pidx_ext[PA_W-1:0];
	assign pf_waddr     = count_ext[SA_W-1:0];

	assign pt_wdata.written = 1'b1;
	assign pt_wdata.x       = point_x;
	assign pt_wdata.y       = point_y;

	// prefix seen by the execute cycle
	assign prev_pf  = ident_q ? afp_pkg::pf_entry_t'{linear: afp_pkg::LIN_IDENTITY,
		shift_x: '0, shift_y: '0} : pf_rdata;
	assign pf_wdata = afp_pkg::compose(prev_pf, kind_q, twop_q);
	assign applied  = afp_pkg::apply(prev_pf, pt_rdata);

	always_comb begin
		state_d  = state_q;
		busy     = clearing || (state_q != afp_pkg::ST_IDLE);
		capture  = 1'b0;
		pt_we    = 1'b0;
		pt_re    = 1'b0;
		pf_re    = 1'b0;
		pf_we    = 1'b0;
		pf_raddr = count_m1_ext[SA_W-1:0];
		ident_d  = 1'b0;
		err_d    = 1'b0;
		case (state_q)
			afp_pkg::ST_IDLE: begin
				if (accept) begin
					case (opcode)
						afp_pkg::OP_LOAD: begin
							// out-of-range slots are dropped
							pt_we = pt_in_range;
						end
						afp_pkg::OP_APPEND: begin
							// a full step table drops the item
							if (step_room) begin
								capture  = 1'b1;
								pf_re    = 1'b1;
								pf_raddr = count_m1_ext[SA_W-1:0];
								ident_d  = (step_count_q == '0);
								state_d  = afp_pkg::ST_EXEC;
							end
						end
						afp_pkg::OP_QUERY: begin
							capture  = 1'b1;
							pt_re    = 1'b1;
							pf_re    = 1'b1;
							pf_raddr = sidx_m1_ext[SA_W-1:0];
							ident_d  = (step_index == 11'd0);
							err_d    = (sidx_ext > count_ext) || !pt_in_range;
							state_d  = afp_pkg::ST_EXEC;
						end
						default: begin
							// unused opcode, nothing to do
						end
					endcase
				end
			end
			afp_pkg::ST_EXEC: begin
				// read data is here: an append writes the new prefix back
				pf_we   = (op_q == afp_pkg::OP_APPEND);
				state_d = afp_pkg::ST_IDLE;
			end
			default: begin
				state_d = afp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= afp_pkg::ST_IDLE;
			step_count_q <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == afp_pkg::ST_EXEC) && (op_q == afp_pkg::OP_QUERY);
			if (pf_we) begin
				step_count_q <= step_count_q + SC_W'(1);
			end
		end
	end

	// captured fields of the item at work
	always_ff @(posedge clk) begin
		if (capture) begin
			op_q    <= opcode;
			kind_q  <= transform_kind;
			twop_q  <= {{(W-32){mirror_line[31]}}, mirror_line[30:0], 1'b0};
			ident_q <= ident_d;
			err_q   <= err_d;
		end
		if ((state_q == afp_pkg::ST_EXEC) && (op_q == afp_pkg::OP_QUERY)) begin
			if (err_q || !pt_rdata.written) begin
				res_x_q   <= '0;
				res_y_q   <= '0;
				res_err_q <= 1'b1;
			end else begin
				res_x_q   <= applied.x;
				res_y_q   <= applied.y;
				res_err_q <= 1'b0;
			end
		end
	end

	afp_point_store #(
		.POINT_SLOTS(POINT_SLOTS)
	) u_points (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (pt_we),
		.re       (pt_re),
		.addr     (pt_addr),
		.wdata    (pt_wdata),
		.rdata    (pt_rdata),
		.clearing (clearing)
	);

	afp_prefix_store #(
		.STEP_SLOTS(STEP_SLOTS)
	) u_prefix (
		.clk   (clk),
		.we    (pf_we),
		.waddr (pf_waddr),
		.wdata (pf_wdata),
		.re    (pf_re),
		.raddr (pf_raddr),
		.rdata (pf_rdata)
	);

	assign done        = done_q;
	assign result_x    = res_x_q;
	assign result_y    = res_y_q;
	assign query_error = res_err_q;

	// a result only follows the execute cycle of a query
	a_done_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == afp_pkg::ST_EXEC && op_q == afp_pkg::OP_QUERY))
		else $error("result strobe without a query in execute");

	// an error result carries zero coordinates
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && query_error) |-> (result_x == '0 && result_y == '0))
		else $error("error result with nonzero coordinates");

	// the step count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(step_count_q) <= 32'(STEP_SLOTS))
		else $error("step count beyond table size");

	// the step count moves by one, and only after an append executes
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(step_count_q != $past(step_count_q)) |->
		(step_count_q == $past(step_count_q) + SC_W'(1) &&
		$past(state_q == afp_pkg::ST_EXEC && op_q == afp_pkg::OP_APPEND)))
		else $error("step count changed outside an append");

	// no item enters while the point flags are being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |=> (state_q == afp_pkg::ST_IDLE && !done))
		else $error("item taken during clear sweep");

endmodule
`default_nettype wire
